// File: hw/rtl/lpfp_pkg.sv
// Shared types and constants of the length-prefixed frame parser.
package lpfp_pkg;

   // Header layout: one type byte, eight sequence bytes, four length bytes.
   localparam logic [3:0] HDR_TYPE_IDX = 4'd0;
   localparam logic [3:0] SEQ_LAST_IDX = 4'd8;
   localparam logic [3:0] HDR_LAST_IDX = 4'd12;
   localparam logic [3:0] HDR_BYTES    = 4'd13;

   // One classified operation passed from the front end to the back end.
   typedef struct packed {
      logic [7:0]  frame_type;
      logic [63:0] sequence_number;
      logic [31:0] payload_length;
      logic [7:0]  payload_byte;
      logic        byte_valid;
      logic        last_of_frame;
   } op_type;

   // One finished result as it is presented on the result ports.
   typedef struct packed {
      logic [7:0]  frame_type;
      logic [63:0] sequence_number;
      logic [31:0] payload_length;
      logic [7:0]  payload_byte;
      logic        byte_valid;
      logic        last_of_frame;
      logic [31:0] frame_count;
      logic [63:0] byte_total;
   } res_type;

endpackage

// File: hw/rtl/lpfp_front.sv
// Front end: tracks the header position and classifies each incoming byte.
module lpfp_front
   import lpfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] data_byte,
   output logic       op_push,
   output op_type     op
);

   logic [3:0]  header_index_ff, header_index_in;
   logic        in_payload_ff, in_payload_in;
   logic [7:0]  held_type_ff, held_type_in;
   logic [63:0] held_seq_ff, held_seq_in;
   logic [31:0] held_len_ff, held_len_in;
   logic [31:0] remaining_ff, remaining_in;

   logic [3:0]  hdr_pos;
   logic [31:0] len_shift;

   always_comb begin
      header_index_in = header_index_ff;
      in_payload_in   = in_payload_ff;
      held_type_in    = held_type_ff;
      held_seq_in     = held_seq_ff;
      held_len_in     = held_len_ff;
      remaining_in    = remaining_ff;
      op_push         = 1'b0;
      op.frame_type      = held_type_ff;
      op.sequence_number = held_seq_ff;
      op.payload_length  = held_len_ff;
      op.payload_byte    = data_byte;
      op.byte_valid      = 1'b1;
      op.last_of_frame   = (remaining_ff == 32'd1);

      // A position beyond the header is treated as the type byte.
      hdr_pos   = (header_index_ff >= HDR_BYTES) ? HDR_TYPE_IDX : header_index_ff;
      len_shift = {held_len_ff[23:0], data_byte};

      if (take) begin
         if (in_payload_ff) begin
            op_push      = 1'b1;
            remaining_in = remaining_ff - 32'd1;
            if (remaining_ff == 32'd1) begin
               in_payload_in   = 1'b0;
               header_index_in = HDR_TYPE_IDX;
            end
         end else begin
            priority if (hdr_pos == HDR_TYPE_IDX) begin
               held_type_in = data_byte;
            end else if (hdr_pos <= SEQ_LAST_IDX) begin
               held_seq_in = {held_seq_ff[55:0], data_byte};
            end else begin
               held_len_in = len_shift;
            end

            if (hdr_pos == HDR_LAST_IDX) begin
               header_index_in = HDR_TYPE_IDX;
               if (len_shift == 32'd0) begin
                  // Empty frame: one result without a byte, marked last.
                  op_push            = 1'b1;
                  op.payload_length  = len_shift;
                  op.payload_byte    = 8'd0;
                  op.byte_valid      = 1'b0;
                  op.last_of_frame   = 1'b1;
               end else begin
                  remaining_in  = len_shift;
                  in_payload_in = 1'b1;
               end
            end else begin
               header_index_in = hdr_pos + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_index_ff <= HDR_TYPE_IDX;
         in_payload_ff   <= 1'b0;
      end else begin
         header_index_ff <= header_index_in;
         in_payload_ff   <= in_payload_in;
      end
      held_type_ff <= held_type_in;
      held_seq_ff  <= held_seq_in;
      held_len_ff  <= held_len_in;
      remaining_ff <= remaining_in;
   end

`ifndef SYNTHESIS
   a_payload_has_bytes: assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> remaining_ff != 32'd0)
      else $error("payload phase with no bytes remaining");

   a_header_pos_range: assert property (@(posedge clock) disable iff (reset)
      $past(reset) == 1'b0 |-> header_index_ff <= HDR_LAST_IDX)
      else $error("header position out of range");
`endif

endmodule

// File: hw/rtl/lpfp_queue.sv
// Short queue of classified operations between the front and back ends.
module lpfp_queue
   import lpfp_pkg::*;
#(
   parameter int DEPTH = 2
)(
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type wdata,
   output logic   full,
   input  logic   pop,
   output logic   empty,
   output op_type rdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   op_type         slots_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= wdata;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count exceeds depth");
`endif

endmodule

// File: hw/rtl/lpfp_back.sv
// Back end: keeps the frame and byte counters and holds the result register.
module lpfp_back
   import lpfp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    op_empty,
   input  op_type  op,
   output logic    op_pop,
   output logic    res_valid,
   input  logic    res_take,
   output res_type res
);

   logic [31:0] frames_ff, frames_in;
   logic [63:0] bytes_ff, bytes_in;
   logic        out_valid_ff, out_valid_in;
   res_type     out_ff, out_in;

   always_comb begin
      op_pop       = !op_empty && (!out_valid_ff || res_take);
      frames_in    = frames_ff;
      bytes_in     = bytes_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !res_take;
      if (op_pop) begin
         frames_in = frames_ff + {31'd0, op.last_of_frame};
         bytes_in  = bytes_ff + {63'd0, op.byte_valid};
         out_in.frame_type      = op.frame_type;
         out_in.sequence_number = op.sequence_number;
         out_in.payload_length  = op.payload_length;
         out_in.payload_byte    = op.payload_byte;
         out_in.byte_valid      = op.byte_valid;
         out_in.last_of_frame   = op.last_of_frame;
         out_in.frame_count     = frames_in;
         out_in.byte_total      = bytes_in;
         out_valid_in           = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff    <= 32'd0;
         bytes_ff     <= 64'd0;
         out_valid_ff <= 1'b0;
      end else begin
         frames_ff    <= frames_in;
         bytes_ff     <= bytes_in;
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign res_valid = out_valid_ff;
   assign res       = out_ff;

`ifndef SYNTHESIS
   a_empty_frame_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.byte_valid) |-> out_ff.last_of_frame)
      else $error("result without a byte is not marked last");
`endif

endmodule

// File: hw/rtl/length_prefixed_frame_parser.sv
// Top level of the length-prefixed frame parser.
//
//   Channel   Direction  Handshake        Payload
//   req_      in         req_push/full    req_data_byte
//   rsp_      out        rsp_empty/pop    frame header fields, byte, flags, counters
//
// The parser takes one byte per clock cycle, every cycle, as long as the
// operation queue between the front and back ends has room.
// A result passes through a queue slot and then the output register before it
// appears on the rsp_ ports; header bytes cause no result.
// Reset is synchronous and active high; it clears the header position, the
// queue and both counters, and the block is ready in the next cycle.
// A stall on the result side fills the output register and then the queue,
// after which req_full rises; input stalls simply leave the queue empty.
module length_prefixed_frame_parser
   import lpfp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_frame_type,
   output logic [63:0] rsp_sequence_number,
   output logic [31:0] rsp_payload_length,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_last_of_frame,
   output logic [31:0] rsp_frame_count,
   output logic [63:0] rsp_byte_total
);

   // A byte transfer happens whenever a byte is offered and the queue can take one more operation.
   // The check is conservative: header bytes also wait on a full queue.
   logic    take;
   logic    q_push, q_full, q_pop, q_empty;
   op_type  q_wdata, q_rdata;
   logic    res_valid;
   res_type res;

   assign take     = req_push && !req_full;
   assign req_full = q_full;

   // The front end walks the header and flags bytes that produce a result.
   lpfp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_data_byte),
      .op_push   (q_push),
      .op        (q_wdata)
   );

   // The queue lets the front keep taking bytes while the result side stalls.
   lpfp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .empty (q_empty),
      .rdata (q_rdata)
   );

   // The back end counts frames and bytes and presents the oldest result.
   lpfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .op_empty  (q_empty),
      .op        (q_rdata),
      .op_pop    (q_pop),
      .res_valid (res_valid),
      .res_take  (rsp_pop),
      .res       (res)
   );

   assign rsp_empty           = !res_valid;
   assign rsp_frame_type      = res.frame_type;
   assign rsp_sequence_number = res.sequence_number;
   assign rsp_payload_length  = res.payload_length;
   assign rsp_payload_byte    = res.payload_byte;
   assign rsp_byte_valid      = res.byte_valid;
   assign rsp_last_of_frame   = res.last_of_frame;
   assign rsp_frame_count     = res.frame_count;
   assign rsp_byte_total      = res.byte_total;

endmodule
